// ===== rtl/rgbg_pkg.sv =====
// shared types and constants for the grey pixel packer
package rgbg_pkg;

    // field widths
    localparam int CODE_W     = 8;
    localparam int GREY_W     = 8;
    localparam int SUM_W      = 15;
    localparam int ADDR_W     = 20;
    localparam int CFG_DATA_W = 11;

    // character offset of the printable encoding
    localparam logic [CODE_W-1:0] CODE_OFFSET = 8'd33;

    // luma weights in hundredths
    localparam logic [SUM_W-1:0] WEIGHT_R = 15'd30;
    localparam logic [SUM_W-1:0] WEIGHT_G = 15'd59;
    localparam logic [SUM_W-1:0] WEIGHT_B = 15'd11;

    // divide by 100 as multiply by ceil(2^22 / 100) and shift, exact for sums below 25501
    localparam int DIV_SHIFT = 22;
    localparam int PROD_W    = 31;
    localparam logic [15:0] DIV100_MUL = 16'd41944;

    // pack mode codes, the unused code behaves as 8 bits per pixel
    localparam logic [1:0] MODE_1BPP = 2'd0;
    localparam logic [1:0] MODE_4BPP = 2'd1;
    localparam logic [1:0] MODE_8BPP = 2'd2;

    // register reset values
    localparam logic [1:0]            RST_PACK_MODE       = MODE_8BPP;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH     = 11'd384;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT    = 11'd288;
    localparam logic [GREY_W-1:0]     RST_WHITE_THRESHOLD = 8'd128;

    // geometry limits
    localparam int MIN_WIDTH  = 8;
    localparam int MIN_HEIGHT = 1;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PACK_MODE       = 2'd0,
        CFG_FRAME_WIDTH     = 2'd1,
        CFG_FRAME_HEIGHT    = 2'd2,
        CFG_WHITE_THRESHOLD = 2'd3
    } cfg_reg_t;

    // one encoded pixel
    typedef struct packed {
        logic [CODE_W-1:0] code_a;
        logic [CODE_W-1:0] code_b;
        logic [CODE_W-1:0] code_c;
        logic [CODE_W-1:0] code_d;
    } pixel_t;

    // one frame buffer word
    typedef struct packed {
        logic [GREY_W-1:0] packed_byte;
        logic [ADDR_W-1:0] byte_address;
        logic              frame_end;
    } fb_word_t;

    // occupancy of the luma pipeline
    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
        logic s3_valid;
    } luma_stat_t;

    // strip the printable offset, wrapping to six bits
    function automatic logic [5:0] six_bits(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] diff;
        diff = code - CODE_OFFSET;
        return diff[5:0];
    endfunction

endpackage

// ===== rtl/rgbg_luma.sv =====
// three stage luma pipeline: input register, weighted sum, divide by 100
module rgbg_luma
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               src_valid,
    output logic                               src_stall,
    input  rgbg_pkg::pixel_t                   src_data,
    output logic                               grey_valid,
    input  logic                               grey_ready,
    output logic [rgbg_pkg::GREY_W-1:0]        grey,
    output rgbg_pkg::luma_stat_t               stat
);

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    rgbg_pkg::pixel_t              s1_pixel_reg;
    logic                          s2_valid_reg;
    logic                          s2_valid_next;
    logic [rgbg_pkg::SUM_W-1:0]    s2_sum_reg;
    logic                          s3_valid_reg;
    logic                          s3_valid_next;
    logic [rgbg_pkg::GREY_W-1:0]   s3_grey_reg;

    logic                          accept;
    logic                          s1_go;
    logic                          s2_go;
    logic                          s3_go;
    logic [5:0]                    sa;
    logic [5:0]                    sb;
    logic [5:0]                    sc;
    logic [5:0]                    sd;
    logic [7:0]                    r;
    logic [7:0]                    g;
    logic [7:0]                    b;
    logic [rgbg_pkg::SUM_W-1:0]    sum;
    logic [rgbg_pkg::PROD_W-1:0]   prod;

    // bubble-collapsing advance chain
    always_comb
    begin
        s3_go     = s3_valid_reg && grey_ready;
        s2_go     = s2_valid_reg && (!s3_valid_reg || s3_go);
        s1_go     = s1_valid_reg && (!s2_valid_reg || s2_go);
        src_stall = s1_valid_reg && s2_valid_reg && !s2_go;
        accept    = src_valid && !src_stall;

        s1_valid_next = accept || (s1_valid_reg && !s1_go);
        s2_valid_next = s1_go || (s2_valid_reg && !s2_go);
        s3_valid_next = s2_go || (s3_valid_reg && !s3_go);
    end

    // unpack the three 8-bit channels and weight them
    always_comb
    begin
        sa  = rgbg_pkg::six_bits(s1_pixel_reg.code_a);
        sb  = rgbg_pkg::six_bits(s1_pixel_reg.code_b);
        sc  = rgbg_pkg::six_bits(s1_pixel_reg.code_c);
        sd  = rgbg_pkg::six_bits(s1_pixel_reg.code_d);
        r   = {sa, sb[5:4]};
        g   = {sb[3:0], sc[5:2]};
        b   = {sc[1:0], sd};
        sum = rgbg_pkg::SUM_W'(r) * rgbg_pkg::WEIGHT_R
            + rgbg_pkg::SUM_W'(g) * rgbg_pkg::WEIGHT_G
            + rgbg_pkg::SUM_W'(b) * rgbg_pkg::WEIGHT_B;
    end

    // truncating divide by 100 through the reciprocal
    always_comb
    begin
        prod = rgbg_pkg::PROD_W'(s2_sum_reg) * rgbg_pkg::PROD_W'(rgbg_pkg::DIV100_MUL);
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= src_data;
        end
        if (s1_go)
        begin
            s2_sum_reg <= sum;
        end
        if (s2_go)
        begin
            s3_grey_reg <= prod[rgbg_pkg::DIV_SHIFT +: rgbg_pkg::GREY_W];
        end
    end

    assign grey_valid    = s3_valid_reg;
    assign grey          = s3_grey_reg;
    assign stat.s1_valid = s1_valid_reg;
    assign stat.s2_valid = s2_valid_reg;
    assign stat.s3_valid = s3_valid_reg;

endmodule

// ===== rtl/rgbg_packer.sv =====
// packs grey levels into frame buffer bytes and tracks the frame position
module rgbg_packer
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   mode_clear,
    input  logic [1:0]                             pack_mode,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]         width_eff,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]        height_eff,
    input  logic [rgbg_pkg::GREY_W-1:0]            white_threshold,
    input  logic                                   grey_valid,
    output logic                                   grey_ready,
    input  logic [rgbg_pkg::GREY_W-1:0]            grey,
    output logic                                   fb_valid,
    input  logic                                   fb_stall,
    output rgbg_pkg::fb_word_t                     fb_data
);

    localparam int WB  = $clog2(MAX_WIDTH + 1);
    localparam int HB  = $clog2(MAX_HEIGHT + 1);
    localparam int WB1 = WB + 1;
    localparam int HB1 = HB + 1;
    localparam int CLW = $clog2(MAX_WIDTH);
    localparam int LNW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PW  = LNW + WB + 1;
    localparam int AW  = (PW > rgbg_pkg::ADDR_W) ? PW : rgbg_pkg::ADDR_W;

    logic [7:0]                 partial_reg;
    logic [7:0]                 partial_next;
    logic [2:0]                 slot_reg;
    logic [2:0]                 slot_next;
    logic [CLW-1:0]             column_reg;
    logic [CLW-1:0]             column_next;
    logic [LNW-1:0]             line_reg;
    logic [LNW-1:0]             line_next;
    logic                       fb_valid_reg;
    logic                       fb_valid_next;
    rgbg_pkg::fb_word_t         fb_data_reg;
    rgbg_pkg::fb_word_t         fb_data_next;

    logic                       step;
    logic [7:0]                 fill;
    logic                       done;
    logic [WB-1:0]              bpl;
    logic                       last_col;
    logic                       last_line;
    logic [AW-1:0]              addr_full;

    // place the grey level into the byte under assembly
    always_comb
    begin
        unique case (pack_mode)
            rgbg_pkg::MODE_1BPP:
            begin
                fill = partial_reg | ((grey >= white_threshold) ? (8'h80 >> slot_reg) : 8'h00);
                done = (slot_reg == 3'd7);
                bpl  = width_eff >> 3;
            end
            rgbg_pkg::MODE_4BPP:
            begin
                fill = partial_reg | (slot_reg[0] ? {grey[7:4], 4'h0} : {4'h0, grey[7:4]});
                done = (slot_reg != 3'd0);
                bpl  = width_eff >> 1;
            end
            default:
            begin
                fill = grey;
                done = 1'b1;
                bpl  = width_eff;
            end
        endcase
    end

    // frame position and byte address
    always_comb
    begin
        last_col  = (WB1'(column_reg) + WB1'(1)) >= WB1'(bpl);
        last_line = (HB1'(line_reg) + HB1'(1)) >= HB1'(height_eff);
        addr_full = AW'(line_reg) * AW'(bpl) + AW'(column_reg);

        if (last_col)
        begin
            column_next = '0;
            line_next   = last_line ? '0 : LNW'(line_reg + 1'b1);
        end
        else
        begin
            column_next = CLW'(column_reg + 1'b1);
            line_next   = line_reg;
        end
    end

    // handshake with the luma pipeline and the output register
    always_comb
    begin
        grey_ready = !fb_valid_reg || !fb_stall;
        step       = grey_valid && grey_ready;

        fb_data_next.packed_byte  = fill;
        fb_data_next.byte_address = addr_full[rgbg_pkg::ADDR_W-1:0];
        fb_data_next.frame_end    = last_col && last_line;

        fb_valid_next = (step && done) || (fb_valid_reg && fb_stall);

        if (mode_clear)
        begin
            partial_next = 8'h00;
            slot_next    = 3'd0;
        end
        else if (step)
        begin
            partial_next = done ? 8'h00 : fill;
            slot_next    = done ? 3'd0 : 3'(slot_reg + 1'b1);
        end
        else
        begin
            partial_next = partial_reg;
            slot_next    = slot_reg;
        end
    end

    // packing and position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg  <= 8'h00;
            slot_reg     <= 3'd0;
            column_reg   <= '0;
            line_reg     <= '0;
            fb_valid_reg <= 1'b0;
        end
        else
        begin
            partial_reg  <= partial_next;
            slot_reg     <= slot_next;
            fb_valid_reg <= fb_valid_next;
            if (step && done)
            begin
                column_reg <= column_next;
                line_reg   <= line_next;
            end
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (step && done)
        begin
            fb_data_reg <= fb_data_next;
        end
    end

    assign fb_valid = fb_valid_reg;
    assign fb_data  = fb_data_reg;

endmodule

// ===== rtl/rgb_to_grey_pixel_packer.sv =====
// top level: configuration registers, luma pipeline and byte packer
// Converts pixels given as four printable characters (33 subtracted, six bits each,
// regrouped into 8-bit r, g and b) to grey = (30r + 59g + 11b) / 100, truncated, and
// packs the grey levels into frame buffer bytes at 8, 4 or 1 bits per pixel, each word
// carrying its byte address and a flag on the last byte of the frame. The block takes
// one pixel every clock cycle while not stalled; a pixel passes an input register, a
// weighted-sum stage, a reciprocal-divide stage and the packing logic into the output
// register, which shows its byte when the pixel completes one. Stall goes high
// only when all three pipeline stages are full and the output word is held. Frame width
// saturates to 8..MAX_WIDTH and height to 1..MAX_HEIGHT; writing the pack mode drops any
// partly assembled byte but keeps the frame position. Configuration is always ready and
// should be written only while no pixel is in flight.
module rgb_to_grey_pixel_packer
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                src_valid,
    output logic                                src_stall,
    input  rgbg_pkg::pixel_t                    src_data,
    output logic                                fb_valid,
    input  logic                                fb_stall,
    output rgbg_pkg::fb_word_t                  fb_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [rgbg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int WC = (WB > rgbg_pkg::CFG_DATA_W) ? WB : rgbg_pkg::CFG_DATA_W;
    localparam int HC = (HB > rgbg_pkg::CFG_DATA_W) ? HB : rgbg_pkg::CFG_DATA_W;

    logic [1:0]                          pack_mode_reg;
    logic [rgbg_pkg::CFG_DATA_W-1:0]     frame_width_reg;
    logic [rgbg_pkg::CFG_DATA_W-1:0]     frame_height_reg;
    logic [rgbg_pkg::GREY_W-1:0]         white_threshold_reg;

    logic                                cfg_write;
    logic                                mode_clear;
    logic [WC-1:0]                       width_wide;
    logic [HC-1:0]                       height_wide;
    logic [WB-1:0]                       width_eff;
    logic [HB-1:0]                       height_eff;
    logic                                grey_valid;
    logic                                grey_ready;
    logic [rgbg_pkg::GREY_W-1:0]         grey;
    rgbg_pkg::luma_stat_t                luma_stat;

    // configuration write decode
    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign mode_clear = cfg_write && (rgbg_pkg::cfg_reg_t'(cfg_index) == rgbg_pkg::CFG_PACK_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_mode_reg       <= rgbg_pkg::RST_PACK_MODE;
            frame_width_reg     <= rgbg_pkg::RST_FRAME_WIDTH;
            frame_height_reg    <= rgbg_pkg::RST_FRAME_HEIGHT;
            white_threshold_reg <= rgbg_pkg::RST_WHITE_THRESHOLD;
        end
        else if (cfg_write)
        begin
            unique case (rgbg_pkg::cfg_reg_t'(cfg_index))
                rgbg_pkg::CFG_PACK_MODE:       pack_mode_reg       <= cfg_data[1:0];
                rgbg_pkg::CFG_FRAME_WIDTH:     frame_width_reg     <= cfg_data;
                rgbg_pkg::CFG_FRAME_HEIGHT:    frame_height_reg    <= cfg_data;
                rgbg_pkg::CFG_WHITE_THRESHOLD: white_threshold_reg <= cfg_data[7:0];
            endcase
        end
    end

    // saturate the frame geometry
    always_comb
    begin
        width_wide  = WC'(frame_width_reg);
        height_wide = HC'(frame_height_reg);

        if (width_wide < WC'(rgbg_pkg::MIN_WIDTH))
            width_eff = WB'(rgbg_pkg::MIN_WIDTH);
        else if (width_wide > WC'(MAX_WIDTH))
            width_eff = WB'(MAX_WIDTH);
        else
            width_eff = WB'(width_wide);

        if (height_wide < HC'(rgbg_pkg::MIN_HEIGHT))
            height_eff = HB'(rgbg_pkg::MIN_HEIGHT);
        else if (height_wide > HC'(MAX_HEIGHT))
            height_eff = HB'(MAX_HEIGHT);
        else
            height_eff = HB'(height_wide);
    end

    // grey conversion pipeline
    rgbg_luma u_luma
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_data   (src_data),
        .grey_valid (grey_valid),
        .grey_ready (grey_ready),
        .grey       (grey),
        .stat       (luma_stat)
    );

    // byte packing and addressing
    rgbg_packer
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_packer
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .mode_clear      (mode_clear),
        .pack_mode       (pack_mode_reg),
        .width_eff       (width_eff),
        .height_eff      (height_eff),
        .white_threshold (white_threshold_reg),
        .grey_valid      (grey_valid),
        .grey_ready      (grey_ready),
        .grey            (grey),
        .fb_valid        (fb_valid),
        .fb_stall        (fb_stall),
        .fb_data         (fb_data)
    );

`ifndef SYNTH
    // an accepted pixel always lands in the input stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid && !src_stall) |=> luma_stat.s1_valid)
        else $error("accepted pixel missing from input stage");

    // upstream stalls only when the whole pipeline is full and blocked
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> (luma_stat.s1_valid && luma_stat.s2_valid
                       && luma_stat.s3_valid && !grey_ready))
        else $error("stall raised with a free pipeline slot");

    // in byte-per-pixel mode every packed pixel yields a word
    a_8bpp_word: assert property (@(posedge clk) disable iff (!rst_n)
        (grey_valid && grey_ready && pack_mode_reg != rgbg_pkg::MODE_1BPP
         && pack_mode_reg != rgbg_pkg::MODE_4BPP) |=> fb_valid)
        else $error("8 bpp pixel produced no word");
`endif

endmodule
